### src/indexed_max_heap_update_macros.svh
// assertion macros for the indexed heap block
`ifndef INDEXED_MAX_HEAP_UPDATE_MACROS_SVH
`define INDEXED_MAX_HEAP_UPDATE_MACROS_SVH
// assert that a implies b at every edge out of reset
`define IMH_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b in the following cycle
`define IMH_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### src/imh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg
// shared types and constants for the indexed max-heap
// ----------------------------------------------------------------------------
package imh_pkg;
    localparam int KeyBits  = 8;
    localparam int Capacity = 256;
    localparam int SlotBits = $clog2(Capacity);
    localparam int CntBits  = $clog2(Capacity + 1);
    localparam int PrioBits = 32;
    localparam int EntBits  = KeyBits + PrioBits;
    localparam int QDepth   = 2;

    localparam logic [1:0] CmdInsert = 2'd0;
    localparam logic [1:0] CmdErase  = 2'd1;
    localparam logic [1:0] CmdPop    = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [KeyBits-1:0]  key;
        logic [PrioBits-1:0] prio;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_KP_RD, S_KP_WT, S_DISPATCH,
        S_LAST_RD, S_LAST_WT, S_FILL,
        S_TOP_RD, S_TOP_WT,
        S_UP_RD, S_UP_WT, S_UP_CMP,
        S_DN_RD, S_DN_WT, S_DN_CMP,
        S_SW_A, S_SW_B,
        S_RES_RD, S_RES_WT, S_OUT
    } t_state;

    // a ranks above b: higher priority, then larger key
    function automatic logic ranks_above(input logic [EntBits-1:0] a,
                                         input logic [EntBits-1:0] b);
        logic signed [PrioBits-1:0] pa, pb;
        pa = a[PrioBits-1:0];
        pb = b[PrioBits-1:0];
        if (pa != pb) return pa > pb;
        return a[EntBits-1:PrioBits] > b[EntBits-1:PrioBits];
    endfunction
endpackage

### src/indexed_max_heap_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_heap_update
// indexed binary max-heap with insert/update, erase by key and pop
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_ready carries cmd, key and priority; a two-entry
//   command queue takes transactions while the engine is busy.
//   output channel o_valid/i_ready returns one result per transaction: the
//   top entry, the count, and whether the key was found.
//   each heap level moved in a sift costs a read, a compare and two writes on
//   the single port of the heap memory; a sift walks at most
//   log2(capacity) = 8 levels.
//   the result is held until taken; the engine waits in its output state,
//   while the queue still accepts up to two further transactions.
//   reset clears the count and the key-present flags at once; the heap and
//   position memories need no clearing and the block is ready right away.
// ----------------------------------------------------------------------------
`include "indexed_max_heap_update_macros.svh"
module indexed_max_heap_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_item_key,
    input  logic signed [31:0] i_item_priority,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_empty,
    output logic [7:0]         o_top_key,
    output logic signed [31:0] o_top_priority,
    output logic [8:0]         o_entry_count,
    output logic               o_key_found
);
    import imh_pkg::*;

    logic q_valid, q_pop;
    t_cmd q_data;

    // front: accept and queue
    imh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_item_key(i_item_key), .i_item_priority(i_item_priority),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data));

    // back: heap engine
    imh_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_data(q_data), .o_valid(o_valid), .i_ready(i_ready),
        .o_is_empty(o_is_empty), .o_top_key(o_top_key),
        .o_top_priority(o_top_priority), .o_entry_count(o_entry_count),
        .o_key_found(o_key_found));

    `IMH_ASSERT_IMPL(a_pop_needs_data, i_clk, i_rst_n, q_pop, q_valid)
    `IMH_ASSERT_IMPL(a_empty_count, i_clk, i_rst_n, o_valid && o_is_empty, o_entry_count == 9'd0)
    `IMH_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
endmodule

### src/imh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### src/imh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_front
// input stage and command queue feeding the heap engine
// ----------------------------------------------------------------------------
module imh_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_item_key,
    input  logic signed [31:0]   i_item_priority,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output imh_pkg::t_cmd        o_q_data
);
    import imh_pkg::*;

    localparam int PtrBits = $clog2(QDepth);
    t_cmd r_q [QDepth];
    logic [PtrBits-1:0] r_wp, r_rp;
    logic [PtrBits:0]   r_cnt;
    logic push;
    t_cmd in_cmd;

    // classify: key trimmed to the key width
    always_comb begin
        in_cmd.cmd  = i_cmd;
        in_cmd.key  = i_item_key[KeyBits-1:0];
        in_cmd.prio = i_item_priority;
    end

    assign o_ready   = (r_cnt < (PtrBits+1)'(QDepth));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_q[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrBits+1)'(push) - (PtrBits+1)'(i_q_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= in_cmd;
    end
endmodule

### src/imh_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_engine
// heap sequencer: lookups, sift up/down and result register
// ----------------------------------------------------------------------------
module imh_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  imh_pkg::t_cmd      i_q_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_empty,
    output logic [7:0]         o_top_key,
    output logic signed [31:0] o_top_priority,
    output logic [8:0]         o_entry_count,
    output logic               o_key_found
);
    import imh_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_op, n_op;
    logic [(1<<KeyBits)-1:0] r_present, n_present;
    logic [CntBits-1:0]  r_count, n_count;
    logic [SlotBits-1:0] r_i, n_i, r_j, n_j;
    logic [EntBits-1:0]  r_ei, n_ei, r_ej, n_ej, r_el, n_el;
    logic [CntBits-1:0]  r_l;
    logic [CntBits-1:0]  n_l;
    logic                r_found, n_found, r_moved, n_moved, r_down, n_down;
    logic                r_onesib, n_onesib;
    logic [EntBits-1:0]  r_res, n_res;

    // memory ports
    logic                 h_we, p_we;
    logic [SlotBits-1:0]  h_addr;
    logic [EntBits-1:0]   h_wdata, h_rdata;
    logic [KeyBits-1:0]   p_addr;
    logic [SlotBits-1:0]  p_wdata, p_rdata;

    imh_ram #(.Width(EntBits), .Depth(Capacity)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_addr(h_addr),
        .i_wdata(h_wdata), .o_rdata(h_rdata));
    imh_ram #(.Width(SlotBits), .Depth(1 << KeyBits)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr),
        .i_wdata(p_wdata), .o_rdata(p_rdata));

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_count   <= n_count;
        end
        r_op <= n_op; r_i <= n_i; r_j <= n_j; r_ei <= n_ei; r_ej <= n_ej;
        r_el <= n_el; r_l <= n_l; r_found <= n_found; r_moved <= n_moved;
        r_down <= n_down; r_onesib <= n_onesib; r_res <= n_res;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_op = r_op; n_present = r_present; n_count = r_count;
        n_i = r_i; n_j = r_j; n_ei = r_ei; n_ej = r_ej; n_el = r_el; n_l = r_l;
        n_found = r_found; n_moved = r_moved; n_down = r_down;
        n_onesib = r_onesib; n_res = r_res;
        h_we = 1'b0; h_addr = r_i; h_wdata = r_ei;
        p_we = 1'b0; p_addr = r_op.key; p_wdata = r_i;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op = i_q_data;
                    n_found = 1'b0;
                    n_moved = 1'b0;
                    n_state = (i_q_data.cmd == CmdPop) ? S_TOP_RD : S_KP_RD;
                end
            end
            // pop: fetch top key then treat as erase; an empty heap goes straight to the result
            S_TOP_RD: begin
                h_addr = '0;
                if (r_count == '0) n_state = S_RES_RD;
                else n_state = S_TOP_WT;
            end
            S_TOP_WT: begin
                n_op.key = h_rdata[EntBits-1:PrioBits];
                n_state = S_KP_RD;
            end
            S_KP_RD: begin
                p_addr = r_op.key;
                n_state = S_KP_WT;
            end
            S_KP_WT: begin
                n_i = p_rdata;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_RES_RD;
                if (r_op.cmd == CmdInsert) begin
                    if (r_present[r_op.key]) begin
                        n_found = 1'b1;
                        n_ei = {r_op.key, r_op.prio};
                        n_state = S_UP_RD;
                    end else if (r_count < CntBits'(Capacity)) begin
                        n_i = r_count[SlotBits-1:0];
                        n_ei = {r_op.key, r_op.prio};
                        n_present[r_op.key] = 1'b1;
                        n_count = r_count + 1'b1;
                        n_state = S_FILL;
                    end
                end else if (r_op.cmd == CmdErase || r_op.cmd == CmdPop) begin
                    if (r_present[r_op.key]) begin
                        n_found = 1'b1;
                        n_present[r_op.key] = 1'b0;
                        n_count = r_count - 1'b1;
                        if (CntBits'(r_i) < r_count - 1'b1) n_state = S_LAST_RD;
                    end
                end
            end
            S_LAST_RD: begin
                h_addr = r_count[SlotBits-1:0];
                n_state = S_LAST_WT;
            end
            S_LAST_WT: begin
                n_ei = h_rdata;
                n_state = S_FILL;
            end
            // write entry at slot i, then try rising
            S_FILL: begin
                h_we = 1'b1; h_addr = r_i; h_wdata = r_ei;
                p_we = 1'b1; p_addr = r_ei[EntBits-1:PrioBits]; p_wdata = r_i;
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                h_we = 1'b1; h_addr = r_i; h_wdata = r_ei;
                if (r_i == '0) begin
                    n_state = r_moved ? S_RES_RD : S_DN_RD;
                end else begin
                    n_j = (r_i - 1'b1) >> 1;
                    n_state = S_UP_WT;
                end
            end
            S_UP_WT: begin
                h_addr = r_j;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                n_ej = h_rdata;
                if (ranks_above(r_ei, h_rdata)) begin
                    n_down = 1'b0;
                    n_state = S_SW_A;
                end else begin
                    n_state = r_moved ? S_RES_RD : S_DN_RD;
                end
            end
            // sift down: read left and right child
            S_DN_RD: begin
                n_l = {r_i, 1'b1};
                if ({1'b0, r_i, 1'b1} >= {1'b0, r_count}) begin
                    n_state = S_RES_RD;
                end else begin
                    h_addr = SlotBits'({r_i, 1'b1});
                    n_onesib = ({r_i, 1'b1} + 1'b1) >= {1'b0, r_count};
                    n_state = S_DN_WT;
                end
            end
            S_DN_WT: begin
                h_addr = SlotBits'(r_l + 1'b1);
                n_ej = h_rdata;
                n_j = r_l[SlotBits-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (!r_onesib && ranks_above(h_rdata, r_ej)) begin
                    n_ej = h_rdata;
                    n_j = SlotBits'(r_l + 1'b1);
                end
                if (ranks_above((!r_onesib && ranks_above(h_rdata, r_ej)) ? h_rdata
                                 : r_ej, r_ei)) begin
                    n_down = 1'b1;
                    n_state = S_SW_A;
                end else begin
                    n_state = S_RES_RD;
                end
            end
            // swap: entry j to slot i and entry i to slot j, move on to slot j
            S_SW_A: begin
                h_we = 1'b1; h_addr = r_i; h_wdata = r_ej;
                p_we = 1'b1; p_addr = r_ej[EntBits-1:PrioBits]; p_wdata = r_i;
                n_state = S_SW_B;
            end
            S_SW_B: begin
                h_we = 1'b1; h_addr = r_j; h_wdata = r_ei;
                p_we = 1'b1; p_addr = r_ei[EntBits-1:PrioBits]; p_wdata = r_j;
                n_i = r_j;
                n_moved = 1'b1;
                n_state = r_down ? S_DN_RD : S_UP_RD;
            end
            S_RES_RD: begin
                h_addr = '0;
                n_state = S_RES_WT;
            end
            S_RES_WT: begin
                n_res = h_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_is_empty     = (r_count == '0);
    assign o_top_key      = o_is_empty ? 8'd0 : 8'(r_res[EntBits-1:PrioBits]);
    assign o_top_priority = o_is_empty ? 32'sd0 : r_res[PrioBits-1:0];
    assign o_entry_count  = 9'(r_count);
    assign o_key_found    = r_found;
endmodule
